// ===== src/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bounded id set
// request modes, field widths and the controller-to-datapath command word
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned IdWidth     = 32;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned CountWidth  = 5;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // one-cycle strobes from the controller
  typedef struct packed {
    logic load;     // capture the request beat
    logic compare;  // register the per-slot match vector
    logic apply;    // update slots and load the result register
  } cmd_t;

endpackage

// ===== src/bis_if.sv =====
// ----------------------------------------------------------------------------
// bis_if: request and response channels of the bounded id set
// valid/ready channels, a beat moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface bis_req_if;
  logic                           valid;
  logic                           ready;
  bis_pkg::mode_e                 mode;
  logic [bis_pkg::IdWidth-1:0]    ident;
  logic [bis_pkg::PosWidth-1:0]   position;

  modport source (output valid, mode, ident, position, input ready);
  modport sink   (input valid, mode, ident, position, output ready);
endinterface

interface bis_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic                            found;
  logic [bis_pkg::IdWidth-1:0]     read_ident;
  logic [bis_pkg::CountWidth-1:0]  count;

  modport source (output valid, status, found, read_ident, count, input ready);
  modport sink   (input valid, status, found, read_ident, count, output ready);
endinterface

// ===== src/bis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bis_ctrl: request sequencer
// accept, compare, apply; owns the response valid flag
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bis_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_APPLY;
      end
      ST_APPLY: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/bis_dpath.sv =====
// ----------------------------------------------------------------------------
// bis_dpath: slot array, match logic and result register
// parallel compare per slot, neighbor shift on remove
// ----------------------------------------------------------------------------
module bis_dpath #(
  parameter int unsigned CAPACITY = bis_pkg::CapacityDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bis_pkg::cmd_t                   cmd_i,
  input  bis_pkg::mode_e                  mode_i,
  input  logic [bis_pkg::IdWidth-1:0]     ident_i,
  input  logic [bis_pkg::PosWidth-1:0]    position_i,
  output logic                            status_o,
  output logic                            found_o,
  output logic [bis_pkg::IdWidth-1:0]     read_ident_o,
  output logic [bis_pkg::CountWidth-1:0]  count_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  bis_pkg::mode_e               mode_q;
  logic [bis_pkg::IdWidth-1:0]  ident_q;
  logic [bis_pkg::PosWidth-1:0] pos_q;

  logic [bis_pkg::IdWidth-1:0]  slots_q [CAPACITY];
  logic [bis_pkg::IdWidth-1:0]  slots_d [CAPACITY];
  logic [CntW-1:0]              occ_q, occ_d;
  logic [CAPACITY-1:0]          match_q;
  logic [CAPACITY-1:0]          at_or_above;

  logic                         status_q, status_d;
  logic                         found_q, found_d;
  logic [bis_pkg::IdWidth-1:0]  rd_q, rd_d;

  logic                         id_zero;
  logic                         hit;
  logic                         full;
  logic                         pos_in_range;
  logic [IdxW-1:0]              occ_idx;

  assign id_zero      = (ident_q == '0);
  assign hit          = |match_q;
  assign full         = (occ_q == CntW'(CAPACITY));
  assign pos_in_range = ({1'b0, pos_q} < (bis_pkg::PosWidth+1)'(CAPACITY));
  assign occ_idx      = occ_q[IdxW-1:0];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      ident_q <= ident_i;
      pos_q   <= position_i;
    end
  end

  // cleared slots hold zero, so a nonzero ident never matches past the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (cmd_i.compare) begin
      for (int k = 0; k < CAPACITY; k++) begin
        match_q[k] <= !id_zero && (slots_q[k] == ident_q);
      end
    end
  end

  // slots at and above the hit shift down on remove
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      acc            = acc | match_q[k];
      at_or_above[k] = acc;
    end
  end

  always_comb begin
    slots_d  = slots_q;
    occ_d    = occ_q;
    status_d = 1'b0;
    found_d  = 1'b0;
    rd_d     = '0;
    unique case (mode_q)
      bis_pkg::MODE_QUERY: begin
        found_d = hit;
      end
      bis_pkg::MODE_ADD: begin
        if (id_zero) begin
          status_d = 1'b1;
        end else if (!hit) begin
          if (full) begin
            status_d = 1'b1;
          end else begin
            slots_d[occ_idx] = ident_q;
            occ_d            = occ_q + CntW'(1);
          end
        end
      end
      bis_pkg::MODE_REMOVE: begin
        if (id_zero || occ_q == '0) begin
          status_d = 1'b1;
        end else if (hit) begin
          for (int k = 0; k < CAPACITY; k++) begin
            if (at_or_above[k]) begin
              slots_d[k] = (k + 1 < CAPACITY) ? slots_q[(k + 1) % CAPACITY] : '0;
            end
          end
          occ_d = occ_q - CntW'(1);
        end
      end
      bis_pkg::MODE_READ: begin
        if (pos_in_range) begin
          rd_d = slots_q[pos_q[IdxW-1:0]];
        end
      end
      default: begin
        rd_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int k = 0; k < CAPACITY; k++) begin
        slots_q[k] <= '0;
      end
    end else if (cmd_i.apply) begin
      occ_q   <= occ_d;
      slots_q <= slots_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      status_q <= status_d;
      found_q  <= found_d;
      rd_q     <= rd_d;
    end
  end

  assign status_o     = status_q;
  assign found_o      = found_q;
  assign read_ident_o = rd_q;
  assign count_o      = bis_pkg::CountWidth'(occ_q);

  // assertions
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(CAPACITY))
    else $error("occupancy above capacity");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("identifier held in more than one slot");

  a_vacant_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> slots_q[occ_idx] == '0)
    else $error("first vacant slot not cleared");

  a_occ_on_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q != $past(occ_q) |-> $past(cmd_i.apply))
    else $error("occupancy changed outside apply");

endmodule

// ===== src/bounded_id_set.sv =====
// ----------------------------------------------------------------------------
// bounded_id_set: packed set of distinct nonzero 32-bit identifiers
// query, add, remove and read-by-position over a bounded slot list
// ----------------------------------------------------------------------------
// each request beat is accepted, compared against every slot in parallel, then
// applied, which updates the slots and loads the result register; a new request
// is accepted in the cycle after apply, so one request is handled at a time,
// and apply waits while the response sink holds off the pending result beat.
// entries stay packed in slots 0..count-1 in order of addition; remove shifts
// the later slots down one place and clears the vacated slot. status flags an
// add of zero or of a new id to a full set and a remove of zero or from an
// empty set; reads at or past the count return zero.
module bounded_id_set #(
  parameter int unsigned CAPACITY = bis_pkg::CapacityDef  // 1 to 31 slots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bis_req_if.sink     req_i,   // request beats
  bis_rsp_if.source   rsp_o    // one result beat per request
);

  bis_pkg::cmd_t cmd;

  // sequencer: decides when to capture, compare and apply
  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // slot storage and the result register
  bis_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (req_i.mode),
    .ident_i      (req_i.ident),
    .position_i   (req_i.position),
    .status_o     (rsp_o.status),
    .found_o      (rsp_o.found),
    .read_ident_o (rsp_o.read_ident),
    .count_o      (rsp_o.count)
  );

endmodule
